// ===== rtl/lsf_pkg.sv =====
package lsf_pkg;

	// Default sizes, handed down through the top level parameters
	localparam int FIFO_DEPTH_DEF = 64;
	localparam int MAX_REQ_DEF    = 32;

	// Depth of the small queues that decouple the stages
	localparam int CMDQ_DEPTH = 2;
	localparam int RESQ_DEPTH = 2;

	// Field widths fixed by the message format
	localparam int MODE_W   = 2;
	localparam int ID_W     = 5;
	localparam int TOTAL_W  = 6;
	localparam int STATUS_W = 3;

	// Message kinds on the input
	localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DONE    = 2'd2;

	// Participant count register
	localparam logic [TOTAL_W-1:0] TOTAL_RESET = 6'd2;
	localparam logic [TOTAL_W-1:0] TOTAL_MIN   = 6'd2;
	localparam logic [TOTAL_W-1:0] TOTAL_LIMIT = 6'd63;

	// Done counter saturates here
	localparam logic [ID_W-1:0] DONE_MAX = 5'd31;

	typedef enum logic [1:0] {
		OP_REQ,
		OP_REL,
		OP_DONE,
		OP_BAD
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK            = 3'd0,
		ST_OVERFLOW      = 3'd1,
		ST_REL_UNLOCKED  = 3'd2,
		ST_UNKNOWN       = 3'd3,
		ST_WAITERS_AT_FIN = 3'd4,
		ST_AFTER_FIN     = 3'd5
	} status_t;

	// Classified command passed from the front to the back
	typedef struct packed {
		op_t             op;
		logic [ID_W-1:0] who;
	} cmd_t;

endpackage

// ===== rtl/lsf_queue.sv =====
module lsf_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	// Store the entry on a push transfer
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/lsf_front.sv =====
module lsf_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [lsf_pkg::MODE_W-1:0] mode,
	input  logic [lsf_pkg::ID_W-1:0]   requester,
	input  logic                    cmd_pop,
	output logic                    cmd_empty,
	output lsf_pkg::cmd_t           cmd
);

	lsf_pkg::cmd_t                     cmd_in;
	logic [$bits(lsf_pkg::cmd_t)-1:0] cmd_raw;

	// Classify the message kind
	always_comb begin
		cmd_in.who = requester;
		case (mode)
			lsf_pkg::MODE_REQUEST: cmd_in.op = lsf_pkg::OP_REQ;
			lsf_pkg::MODE_RELEASE: cmd_in.op = lsf_pkg::OP_REL;
			lsf_pkg::MODE_DONE:    cmd_in.op = lsf_pkg::OP_DONE;
			default:               cmd_in.op = lsf_pkg::OP_BAD;
		endcase
	end

	// Hold classified commands until the back end takes them
	lsf_queue #(
		.WIDTH ($bits(lsf_pkg::cmd_t)),
		.DEPTH (lsf_pkg::CMDQ_DEPTH)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_raw),
		.empty  (cmd_empty)
	);

	assign cmd = lsf_pkg::cmd_t'(cmd_raw);

endmodule

// ===== rtl/lsf_back.sv =====
module lsf_back #(
	parameter int FIFO_DEPTH     = lsf_pkg::FIFO_DEPTH_DEF,
	parameter int MAX_REQUESTERS = lsf_pkg::MAX_REQ_DEF,
	parameter int CNT_W          = $clog2(FIFO_DEPTH + 1),
	parameter int RES_W          = 2 + lsf_pkg::ID_W + CNT_W + lsf_pkg::STATUS_W
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [lsf_pkg::TOTAL_W-1:0] cfg_wr_data,
	input  logic                       cmd_empty,
	input  lsf_pkg::cmd_t              cmd,
	output logic                       cmd_pop,
	input  logic                       res_full,
	output logic                       res_push,
	output logic [RES_W-1:0]           res_data
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam logic [lsf_pkg::TOTAL_W-1:0] TOTAL_CAP =
		(MAX_REQUESTERS > 63) ? lsf_pkg::TOTAL_LIMIT : lsf_pkg::TOTAL_W'(MAX_REQUESTERS);

	logic [lsf_pkg::ID_W-1:0]    wait_mem [FIFO_DEPTH];
	logic [lsf_pkg::ID_W-1:0]    rd_mem_q;
	logic [lsf_pkg::ID_W-1:0]    byp_data_q;
	logic                        byp_q;
	logic [lsf_pkg::ID_W-1:0]    head_val;

	logic [PTR_W-1:0]            head_q, head_d;
	logic [PTR_W-1:0]            tail_q, tail_d;
	logic [CNT_W-1:0]            cnt_q, cnt_d;
	logic                        lock_q, lock_d;
	logic [lsf_pkg::ID_W-1:0]    done_q, done_d;
	logic                        fin_q, fin_d;
	logic [lsf_pkg::TOTAL_W-1:0] total_q;

	logic                        exec;
	logic                        wr_en;
	logic                        check;
	logic                        gv;
	logic [lsf_pkg::ID_W-1:0]    tgt;
	lsf_pkg::status_t            status;

	function automatic logic [PTR_W-1:0] slot_next(input logic [PTR_W-1:0] p);
		slot_next = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign exec     = !cmd_empty && !res_full;
	assign cmd_pop  = exec;
	assign res_push = exec;
	assign head_val = byp_q ? byp_data_q : rd_mem_q;

	// Execute one command and decide the grant
	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		cnt_d  = cnt_q;
		lock_d = lock_q;
		done_d = done_q;
		fin_d  = fin_q;
		wr_en  = 1'b0;
		check  = 1'b1;
		gv     = 1'b0;
		tgt    = '0;
		status = lsf_pkg::ST_OK;
		if (exec) begin
			if (fin_q) begin
				status = lsf_pkg::ST_AFTER_FIN;
				check  = 1'b0;
			end else begin
				case (cmd.op)
					lsf_pkg::OP_REQ: begin
						if (cnt_q == CNT_W'(FIFO_DEPTH)) begin
							status = lsf_pkg::ST_OVERFLOW;
						end else begin
							wr_en  = 1'b1;
							tail_d = slot_next(tail_q);
							cnt_d  = cnt_q + 1'b1;
						end
					end
					lsf_pkg::OP_REL: begin
						if (!lock_q) begin
							status = lsf_pkg::ST_REL_UNLOCKED;
						end else begin
							lock_d = 1'b0;
						end
					end
					lsf_pkg::OP_DONE: begin
						if (done_q != lsf_pkg::DONE_MAX) begin
							done_d = done_q + 1'b1;
						end
						if ({1'b0, done_d} + 6'd1 >= total_q) begin
							fin_d = 1'b1;
							check = 1'b0;
							if (cnt_q != '0) begin
								status = lsf_pkg::ST_WAITERS_AT_FIN;
							end
						end
					end
					default: begin
						status = lsf_pkg::ST_UNKNOWN;
					end
				endcase
			end
			// Grant the oldest waiter; an empty queue before this step means it is the sender
			if (check && !lock_d && cnt_d != '0) begin
				gv     = 1'b1;
				tgt    = (cnt_q == '0) ? cmd.who : head_val;
				head_d = slot_next(head_q);
				cnt_d  = cnt_d - 1'b1;
				lock_d = 1'b1;
			end
		end
	end

	assign res_data = {gv, tgt, fin_d, cnt_d, status};

	// Write the waiter memory and prefetch the next head entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			wait_mem[tail_q] <= cmd.who;
		end
		rd_mem_q   <= wait_mem[head_d];
		byp_q      <= wr_en && (tail_q == head_d);
		byp_data_q <= cmd.who;
	end

	// Hold lock and queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
			lock_q <= 1'b0;
			done_q <= '0;
			fin_q  <= 1'b0;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			cnt_q  <= cnt_d;
			lock_q <= lock_d;
			done_q <= done_d;
			fin_q  <= fin_d;
		end
	end

	// Clamp the participant count when written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= lsf_pkg::TOTAL_RESET;
		end else if (cfg_wr_en) begin
			if (cfg_wr_data < lsf_pkg::TOTAL_MIN) begin
				total_q <= lsf_pkg::TOTAL_MIN;
			end else if (cfg_wr_data > TOTAL_CAP) begin
				total_q <= TOTAL_CAP;
			end else begin
				total_q <= cfg_wr_data;
			end
		end
	end

endmodule

// ===== rtl/fifo_lock_server_top.sv =====
// Channel   Handshake      Payload
// input     push / full    mode, requester
// result    pop / empty    grant_valid, grant_target, finished, queue_length, status
// config    cfg_wr_en      cfg_wr_data (participant count, clamped on write)
//
// One message per cycle sustained while the result queue has room; the back end updates the lock, the waiter
// pointers and the head prefetch of the waiter memory together.
// A pushed message is registered in the command queue; the back end then executes it into the result queue.
// Reset clears pointers, counts, lock and finish state; the waiter memory needs no clearing.
// A full result queue stalls the back end; the command queue then fills and raises full.
module fifo_lock_server_top #(
	parameter int FIFO_DEPTH     = lsf_pkg::FIFO_DEPTH_DEF,
	parameter int MAX_REQUESTERS = lsf_pkg::MAX_REQ_DEF,
	parameter int CNT_W          = $clog2(FIFO_DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [lsf_pkg::TOTAL_W-1:0]   cfg_wr_data,
	input  logic                          push,
	output logic                          full,
	input  logic [lsf_pkg::MODE_W-1:0]    mode,
	input  logic [lsf_pkg::ID_W-1:0]      requester,
	input  logic                          pop,
	output logic                          empty,
	output logic                          grant_valid,
	output logic [lsf_pkg::ID_W-1:0]      grant_target,
	output logic                          finished,
	output logic [CNT_W-1:0]              queue_length,
	output logic [lsf_pkg::STATUS_W-1:0]  status
);

	localparam int RES_W = 2 + lsf_pkg::ID_W + CNT_W + lsf_pkg::STATUS_W;

	lsf_pkg::cmd_t    cmd;
	logic             cmd_empty;
	logic             cmd_pop;
	logic             res_full;
	logic             res_push;
	logic [RES_W-1:0] res_in;
	logic [RES_W-1:0] res_out;

	lsf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.requester (requester),
		.cmd_pop   (cmd_pop),
		.cmd_empty (cmd_empty),
		.cmd       (cmd)
	);

	lsf_back #(
		.FIFO_DEPTH     (FIFO_DEPTH),
		.MAX_REQUESTERS (MAX_REQUESTERS),
		.CNT_W          (CNT_W),
		.RES_W          (RES_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd_empty   (cmd_empty),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop),
		.res_full    (res_full),
		.res_push    (res_push),
		.res_data    (res_in)
	);

	// Hold results until the consumer takes them
	lsf_queue #(
		.WIDTH (RES_W),
		.DEPTH (lsf_pkg::RESQ_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	// Split the result word into fields
	assign status       = res_out[lsf_pkg::STATUS_W-1:0];
	assign queue_length = res_out[lsf_pkg::STATUS_W +: CNT_W];
	assign finished     = res_out[lsf_pkg::STATUS_W + CNT_W];
	assign grant_target = res_out[lsf_pkg::STATUS_W + CNT_W + 1 +: lsf_pkg::ID_W];
	assign grant_valid  = res_out[RES_W-1];

	// No grant on the finishing step or after it
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && grant_valid |-> !finished)
		else $error("grant reported together with finished");

	// Messages after finish report finished
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status == lsf_pkg::ST_AFTER_FIN |-> finished)
		else $error("after-finish status without finished flag");

	// Waiter count never exceeds the memory depth
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> queue_length <= CNT_W'(FIFO_DEPTH))
		else $error("queue length beyond waiter memory depth");

	// Every command taken by the back end yields exactly one result
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop == res_push && (!cmd_pop || (!cmd_empty && !res_full)))
		else $error("command and result transfers out of step");

endmodule

// ===== tb/sv/fifo_lock_server_top_tb.sv =====
module fifo_lock_server_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WAIT_DEPTH = lsf_pkg::FIFO_DEPTH_DEF;
	localparam int REQ_LIMIT  = lsf_pkg::MAX_REQ_DEF;
	localparam int QLEN_W     = $clog2(WAIT_DEPTH + 1);
	localparam int ID_MAX     = (1 << lsf_pkg::ID_W) - 1;

	// One expected reply of the lock server
	typedef struct {
		logic                      grant_valid;
		logic [lsf_pkg::ID_W-1:0]  grant_target;
		logic                      finished;
		logic [QLEN_W-1:0]         queue_length;
		lsf_pkg::status_t          status;
	} reply_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_wr_en = 1'b0;
	logic [lsf_pkg::TOTAL_W-1:0]  cfg_wr_data = '0;
	logic                         push = 1'b0;
	logic                         full;
	logic [lsf_pkg::MODE_W-1:0]   mode = '0;
	logic [lsf_pkg::ID_W-1:0]     requester = '0;
	logic                         pop = 1'b0;
	logic                         empty;
	logic                         grant_valid;
	logic [lsf_pkg::ID_W-1:0]     grant_target;
	logic                         finished;
	logic [QLEN_W-1:0]            queue_length;
	logic [lsf_pkg::STATUS_W-1:0] status;

	// Lock server state as the testbench sees it
	logic [lsf_pkg::ID_W-1:0]    waiters[$];
	bit                          lock_busy = 1'b0;
	int unsigned                 done_seen = 0;
	bit                          server_done = 1'b0;
	logic [lsf_pkg::TOTAL_W-1:0] total_reg = lsf_pkg::TOTAL_RESET;

	reply_t pending_replies[$];

	int idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int msgs_sent = 0;
	int replies_checked = 0;
	int grants_made = 0;
	int total_writes = 0;
	int status_hits[6] = '{default: 0};

	fifo_lock_server_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.push         (push),
		.full         (full),
		.mode         (mode),
		.requester    (requester),
		.pop          (pop),
		.empty        (empty),
		.grant_valid  (grant_valid),
		.grant_target (grant_target),
		.finished     (finished),
		.queue_length (queue_length),
		.status       (status)
	);

	always #5 clk = ~clk;

	// Participant count after clamping into the legal range
	function automatic int unsigned participants();
		int unsigned t;
		t = total_reg;
		if (t < 2) t = 2;
		if (t > REQ_LIMIT) t = REQ_LIMIT;
		return t;
	endfunction

	// Apply one message to the lock state and queue the reply it yields
	task automatic serve_message(input lsf_pkg::op_t op, input logic [lsf_pkg::ID_W-1:0] who);
		reply_t r;
		bit try_grant;
		r.grant_valid = 1'b0;
		r.grant_target = '0;
		r.status = lsf_pkg::ST_OK;
		try_grant = 1'b1;
		if (server_done) begin
			r.status = lsf_pkg::ST_AFTER_FIN;
			try_grant = 1'b0;
		end else begin
			case (op)
				lsf_pkg::OP_REQ: begin
					if (waiters.size() >= WAIT_DEPTH) r.status = lsf_pkg::ST_OVERFLOW;
					else waiters.push_back(who);
				end
				lsf_pkg::OP_REL: begin
					if (!lock_busy) r.status = lsf_pkg::ST_REL_UNLOCKED;
					else lock_busy = 1'b0;
				end
				lsf_pkg::OP_DONE: begin
					if (done_seen < lsf_pkg::DONE_MAX) done_seen++;
					if (done_seen >= participants() - 1) begin
						server_done = 1'b1;
						try_grant = 1'b0;
						if (waiters.size() > 0) r.status = lsf_pkg::ST_WAITERS_AT_FIN;
					end
				end
				default: begin
					r.status = lsf_pkg::ST_UNKNOWN;
				end
			endcase
		end
		// Hand the lock to the oldest waiter when it is free
		if (try_grant && !lock_busy && waiters.size() > 0) begin
			r.grant_valid = 1'b1;
			r.grant_target = waiters.pop_front();
			lock_busy = 1'b1;
			grants_made++;
		end
		r.finished = server_done;
		r.queue_length = QLEN_W'(waiters.size());
		status_hits[r.status]++;
		pending_replies.push_back(r);
	endtask

	// Offer one message and hold it until the transfer happens
	task automatic send_msg(input lsf_pkg::op_t op, input logic [lsf_pkg::ID_W-1:0] who);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		mode <= op;
		requester <= who;
		do @(posedge clk); while (full);
		serve_message(op, who);
		msgs_sent++;
	endtask

	// Drop push and wait until every reply has been taken
	task automatic quiesce();
		@(negedge clk);
		push <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_total(input logic [lsf_pkg::TOTAL_W-1:0] value);
		quiesce();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		total_reg = value;
		total_writes++;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Weighted message kind; a done that would end the session becomes a request
	function automatic lsf_pkg::op_t pick_op(input int req_w, input int rel_w, input int bad_w,
			input int done_w);
		int roll;
		lsf_pkg::op_t op;
		roll = $urandom_range(req_w + rel_w + bad_w + done_w - 1);
		if (roll < req_w) op = lsf_pkg::OP_REQ;
		else if (roll < req_w + rel_w) op = lsf_pkg::OP_REL;
		else if (roll < req_w + rel_w + bad_w) op = lsf_pkg::OP_BAD;
		else op = lsf_pkg::OP_DONE;
		if (op == lsf_pkg::OP_DONE && done_seen + 1 >= participants() - 1) op = lsf_pkg::OP_REQ;
		return op;
	endfunction

	task automatic run_burst(input int count, input int req_w, input int rel_w,
			input int bad_w, input int done_w);
		int i;
		for (i = 0; i < count; i++)
			send_msg(pick_op(req_w, rel_w, bad_w, done_w),
				lsf_pkg::ID_W'($urandom_range(ID_MAX)));
	endtask

	// Lock hand-over, queue order, error codes and a done that does not finish
	task automatic test_basic_lock();
		idle_pct = 0;
		stall_pct = 0;
		write_total(6'd63);
		send_msg(lsf_pkg::OP_REL, 5'd3);
		send_msg(lsf_pkg::OP_REQ, 5'd0);
		send_msg(lsf_pkg::OP_REQ, lsf_pkg::ID_W'(ID_MAX));
		send_msg(lsf_pkg::OP_REQ, 5'd17);
		send_msg(lsf_pkg::OP_BAD, lsf_pkg::ID_W'(ID_MAX));
		send_msg(lsf_pkg::OP_REL, 5'd0);
		send_msg(lsf_pkg::OP_REL, lsf_pkg::ID_W'(ID_MAX));
		send_msg(lsf_pkg::OP_REL, 5'd17);
		send_msg(lsf_pkg::OP_DONE, lsf_pkg::ID_W'(ID_MAX));
		send_msg(lsf_pkg::OP_BAD, 5'd0);
		send_msg(lsf_pkg::OP_REQ, 5'd5);
		send_msg(lsf_pkg::OP_DONE, 5'd0);
		send_msg(lsf_pkg::OP_REL, 5'd5);
	endtask

	// Short bursts under register values at and beyond the clamp limits
	task automatic test_register_extremes();
		logic [lsf_pkg::TOTAL_W-1:0] values[5] = '{6'd0, 6'd1, 6'd2, 6'd32, 6'd33};
		int k;
		for (k = 0; k < 5; k++) begin
			write_total(values[k]);
			run_burst(12, 40, 40, 10, 10);
		end
	endtask

	// Long random traffic: balanced, filling past overflow, balanced under stalls, then draining
	task automatic test_random_traffic();
		write_total(6'd63);
		idle_pct = 0;
		stall_pct = 0;
		run_burst(190, 40, 40, 10, 2);
		write_total(6'd33);
		idle_pct = 51;
		stall_pct = 0;
		run_burst(190, 80, 12, 4, 2);
		write_total(6'd32);
		idle_pct = 0;
		stall_pct = 51;
		run_burst(190, 45, 45, 6, 2);
		write_total(6'd31);
		idle_pct = 18;
		stall_pct = 18;
		run_burst(190, 20, 70, 6, 2);
	endtask

	// Finish with waiters queued after lowering the count, then reject everything
	task automatic test_finish();
		idle_pct = 18;
		stall_pct = 18;
		send_msg(lsf_pkg::OP_REQ, 5'd3);
		send_msg(lsf_pkg::OP_REQ, 5'd12);
		send_msg(lsf_pkg::OP_REQ, 5'd27);
		write_total(6'd0);
		send_msg(lsf_pkg::OP_DONE, 5'd9);
		send_msg(lsf_pkg::OP_REQ, 5'd0);
		send_msg(lsf_pkg::OP_REL, lsf_pkg::ID_W'(ID_MAX));
		send_msg(lsf_pkg::OP_DONE, 5'd0);
		send_msg(lsf_pkg::OP_BAD, lsf_pkg::ID_W'(ID_MAX));
		run_burst(20, 25, 25, 25, 25);
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Drive pop at random; stall as the current phase asks
	always @(negedge clk) begin
		pop <= ($urandom_range(99) >= stall_pct);
	end

	// Compare every transfer on the result side with the oldest expected reply
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && pop && !empty) begin
			if (pending_replies.size() == 0) begin
				$error("unexpected reply: grant_valid %0d grant_target %0d status %0d",
					grant_valid, grant_target, status);
				errors++;
			end else begin
				want = pending_replies.pop_front();
				check_field("grant_valid", 8'(want.grant_valid), 8'(grant_valid));
				check_field("grant_target", 8'(want.grant_target), 8'(grant_target));
				check_field("finished", 8'(want.finished), 8'(finished));
				check_field("queue_length", 8'(want.queue_length), 8'(queue_length));
				check_field("status", 8'(want.status), 8'(status));
				replies_checked++;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_basic_lock();
		test_register_extremes();
		test_random_traffic();
		test_finish();
		quiesce();
		$display("Run covered %0d messages, %0d replies checked, %0d grants, %0d register writes",
			msgs_sent, replies_checked, grants_made, total_writes);
		$display("Status counts: ok %0d, overflow %0d, release unlocked %0d, unknown %0d, %s %0d, %s %0d",
			status_hits[0], status_hits[1], status_hits[2], status_hits[3],
			"waiters at finish", status_hits[4], "after finish", status_hits[5]);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#2ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
